>>> hdl/dbsm_pkg.sv
package dbsm_pkg;

    localparam int MAX_BUFFERS_DEFAULT = 8;
    localparam int FLIP_DEPTH_DEFAULT  = 16;
    localparam int SLOT_FIELD_LIMIT    = 8;

    localparam logic [2:0] ACT_DEQUEUE  = 3'd0;
    localparam logic [2:0] ACT_QUEUE    = 3'd1;
    localparam logic [2:0] ACT_CANCEL   = 3'd2;
    localparam logic [2:0] ACT_PULL     = 3'd3;
    localparam logic [2:0] ACT_COMPLETE = 3'd4;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_BAD_INDEX      = 3'd1,
        ST_NOT_DEQUEUED   = 3'd2,
        ST_ALREADY_QUEUED = 3'd3,
        ST_NONE_FREE      = 3'd4,
        ST_FLIP_EMPTY     = 3'd5,
        ST_FLIP_FULL      = 3'd6,
        ST_NOT_DISPLAYED  = 3'd7
    } status_t;

    typedef struct packed {
        logic       empty;
        logic       skip_plane;
        logic [2:0] slot;
    } flip_entry_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        status_t    status;
        logic [2:0] slot_index;
        logic       empty_flip;
        logic       flip_skip_plane;
        logic [3:0] dequeued_count;
        logic [7:0] used_bits;
        logic [7:0] queued_bits;
    } result_t;

endpackage

>>> hdl/display_buffer_slot_manager.sv
// Channel  Direction  Signals                          Contents
// s_       in         s_tvalid s_tready s_tdata s_tuser  one action
// m_       out        m_tvalid m_tready m_tdata m_tuser  one result per action
// cfg_     in         cfg_valid cfg_ready cfg_data       buffer_count register
//
// Each input transaction has its action captured in state CS_IDLE and executed in
// CS_EXEC, the execute state being needed for the registered read of the flip memory.
// The result goes to an output register, so execution stalls only while that
// register still holds an untaken result.
// Reset is synchronous and active low; it clears the slot masks, counts and
// flip queue pointers at once, with no clearing pass over the flip memory.
module display_buffer_slot_manager #(
    parameter int MAX_BUFFERS = dbsm_pkg::MAX_BUFFERS_DEFAULT,
    parameter int FLIP_DEPTH  = dbsm_pkg::FLIP_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] slot_sel, [3] skip_plane
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] status, [5:3] slot_index, [6] flip_skip_plane,
                                   // [10:7] dequeued_count, [18:11] used_bits,
                                   // [26:19] queued_bits
    output logic        m_tuser,   // [0] empty_flip
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    dbsm_pkg::ctrl_cmd_t cmd;
    dbsm_pkg::result_t   result;

    dbsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    dbsm_datapath #(
        .MAX_BUFFERS (MAX_BUFFERS),
        .FLIP_DEPTH  (FLIP_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg_we        (cfg_valid),
        .cfg_data      (cfg_data),
        .in_action     (s_tuser),
        .in_index      (s_tdata[2:0]),
        .in_skip_plane (s_tdata[3]),
        .result        (result)
    );

    assign cfg_ready = 1'b1;
    assign m_tuser   = result.empty_flip;
    assign m_tdata   = {5'd0, result.queued_bits, result.used_bits, result.dequeued_count,
                        result.flip_skip_plane, result.slot_index, result.status};

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an action was still executing");

    a_empty_pull_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:0] == dbsm_pkg::ST_FLIP_EMPTY)) |->
        (m_tdata[5:3] == 3'd0 && !m_tuser && !m_tdata[6]))
        else $error("failed pull carries flip entry fields");

    a_empty_flip_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[5:3] == 3'd0 && m_tdata[2:0] == dbsm_pkg::ST_OK))
        else $error("empty flip reported with a slot or a failing status");

endmodule

>>> hdl/dbsm_ctrl.sv
module dbsm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output dbsm_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        CS_IDLE = 2'b01,
        CS_EXEC = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.commit     = 1'b0;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            CS_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == CS_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

>>> hdl/dbsm_datapath.sv
module dbsm_datapath #(
    parameter int MAX_BUFFERS = dbsm_pkg::MAX_BUFFERS_DEFAULT,
    parameter int FLIP_DEPTH  = dbsm_pkg::FLIP_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dbsm_pkg::ctrl_cmd_t cmd,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_data,
    input  logic [2:0]          in_action,
    input  logic [2:0]          in_index,
    input  logic                in_skip_plane,
    output dbsm_pkg::result_t   result
);

    localparam int SLOTS = (MAX_BUFFERS < dbsm_pkg::SLOT_FIELD_LIMIT) ?
                           MAX_BUFFERS : dbsm_pkg::SLOT_FIELD_LIMIT;
    localparam int AW    = (FLIP_DEPTH > 2) ? $clog2(FLIP_DEPTH) : 1;
    localparam int FW    = $clog2(FLIP_DEPTH + 1);

    logic [3:0]       bc_reg;
    logic [SLOTS-1:0] use_reg, queued_reg;
    logic [3:0]       cnt_reg;
    logic [AW-1:0]    head_reg, tail_reg;
    logic [FW-1:0]    fill_reg;
    logic [2:0]       act_reg;
    logic [2:0]       idx_reg;
    logic             np_reg;

    dbsm_pkg::flip_entry_t fifo_mem [FLIP_DEPTH];
    dbsm_pkg::flip_entry_t rd_reg;
    dbsm_pkg::flip_entry_t wr_entry;
    dbsm_pkg::result_t     result_reg, result_next;

    logic [7:0]    use_ext, queued_ext, use_n, queued_n, lane, bit_sel, free;
    logic [3:0]    n, cnt_n;
    logic [AW-1:0] head_n, tail_n;
    logic [FW-1:0] fill_n;
    logic          in_range, found, push, fifo_full;
    logic [2:0]    first;

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
        return (p == AW'(FLIP_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        use_ext    = 8'(use_reg);
        queued_ext = 8'(queued_reg);
        n          = (bc_reg > 4'(SLOTS)) ? 4'(SLOTS) : bc_reg;
        lane       = 8'((9'd1 << n) - 9'd1);
        bit_sel    = 8'd1 << idx_reg;
        in_range   = {1'b0, idx_reg} < n;
        fifo_full  = (fill_reg == FW'(FLIP_DEPTH));
        free       = ~use_ext & lane;
        found      = 1'b0;
        first      = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (free[i]) begin
                found = 1'b1;
                first = 3'(i);
            end
        end

        use_n    = use_ext;
        queued_n = queued_ext;
        cnt_n    = cnt_reg;
        head_n   = head_reg;
        tail_n   = tail_reg;
        fill_n   = fill_reg;
        push     = 1'b0;
        wr_entry = '0;
        wr_entry.skip_plane = np_reg;

        result_next               = '0;
        result_next.status        = dbsm_pkg::ST_OK;

        unique case (act_reg)
            dbsm_pkg::ACT_DEQUEUE: begin
                if (found) begin
                    use_n                  = use_ext | (8'd1 << first);
                    cnt_n                  = (cnt_reg != 4'd15) ? cnt_reg + 4'd1 : cnt_reg;
                    result_next.slot_index = first;
                end else begin
                    result_next.status = dbsm_pkg::ST_NONE_FREE;
                end
            end
            dbsm_pkg::ACT_QUEUE: begin
                if (!in_range) begin
                    result_next.status = dbsm_pkg::ST_BAD_INDEX;
                end else if ((use_ext & bit_sel) == 8'd0) begin
                    result_next.status = dbsm_pkg::ST_NOT_DEQUEUED;
                end else if ((queued_ext & bit_sel) != 8'd0) begin
                    result_next.status = dbsm_pkg::ST_ALREADY_QUEUED;
                end else if (fifo_full) begin
                    result_next.status = dbsm_pkg::ST_FLIP_FULL;
                end else begin
                    queued_n      = queued_ext | bit_sel;
                    push          = 1'b1;
                    wr_entry.slot = idx_reg;
                end
            end
            dbsm_pkg::ACT_CANCEL: begin
                if (!in_range) begin
                    result_next.status = dbsm_pkg::ST_BAD_INDEX;
                end else if ((use_ext & bit_sel) == 8'd0) begin
                    result_next.status = dbsm_pkg::ST_NOT_DEQUEUED;
                end else if (fifo_full) begin
                    result_next.status = dbsm_pkg::ST_FLIP_FULL;
                end else begin
                    use_n          = use_ext & ~bit_sel;
                    cnt_n          = (cnt_reg != 4'd0) ? cnt_reg - 4'd1 : cnt_reg;
                    push           = 1'b1;
                    wr_entry.empty = 1'b1;
                end
            end
            dbsm_pkg::ACT_PULL: begin
                if (fill_reg == '0) begin
                    result_next.status = dbsm_pkg::ST_FLIP_EMPTY;
                end else begin
                    result_next.empty_flip      = rd_reg.empty;
                    result_next.flip_skip_plane = rd_reg.skip_plane;
                    result_next.slot_index      = rd_reg.empty ? 3'd0 : rd_reg.slot;
                    head_n                      = wrap_next(head_reg);
                    fill_n                      = fill_reg - FW'(1);
                end
            end
            dbsm_pkg::ACT_COMPLETE: begin
                if (!in_range) begin
                    result_next.status = dbsm_pkg::ST_BAD_INDEX;
                end else begin
                    cnt_n = (cnt_reg != 4'd0) ? cnt_reg - 4'd1 : cnt_reg;
                    if ((use_ext & bit_sel) != 8'd0) begin
                        use_n    = use_ext & ~bit_sel;
                        queued_n = queued_ext & ~bit_sel;
                    end else begin
                        result_next.status = dbsm_pkg::ST_NOT_DISPLAYED;
                    end
                end
            end
            default: begin
            end
        endcase

        if (push) begin
            tail_n = wrap_next(tail_reg);
            fill_n = fill_reg + FW'(1);
        end

        result_next.dequeued_count = cnt_n;
        result_next.used_bits      = use_n;
        result_next.queued_bits    = queued_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg     <= '0;
            use_reg    <= '0;
            queued_reg <= '0;
            cnt_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
        end else begin
            if (cfg_we) begin
                bc_reg <= cfg_data;
            end
            if (cmd.commit) begin
                use_reg    <= use_n[SLOTS-1:0];
                queued_reg <= queued_n[SLOTS-1:0];
                cnt_reg    <= cnt_n;
                head_reg   <= head_n;
                tail_reg   <= tail_n;
                fill_reg   <= fill_n;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= in_action;
            idx_reg <= in_index;
            np_reg  <= in_skip_plane;
        end
        if (cmd.commit) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && push) begin
            fifo_mem[tail_reg] <= wr_entry;
        end
        rd_reg <= fifo_mem[head_reg];
    end

    assign result = result_reg;

endmodule
